[rtl/ssme_pkg.sv]
// ----------------------------------------------------------------------------
// ssme_pkg: shared types and constants of the skinning matrix engine
// Command word passed from the front end to the back end, result record and
// fixed-point constants.
// ----------------------------------------------------------------------------
package ssme_pkg;

  localparam int BONE_W      = 7;
  localparam int ELEM_W      = 4;
  localparam int VAL_W       = 32;
  localparam int Q_W         = 16;
  localparam int CFG_W       = 8;
  localparam int VALID_DEPTH = 128;

  // item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POSE = 1'b1;

  // 1.0 in Q16.16
  localparam logic signed [VAL_W-1:0] Q16_ONE = 32'sd65536;

  // classified item handed to the back end
  typedef struct packed {
    logic                    is_pose;
    logic                    frame_start;
    logic                    parent_ok;
    logic [BONE_W-1:0]       bone;
    logic [ELEM_W-1:0]       elem;
    logic signed [VAL_W-1:0] value;
    logic [BONE_W-1:0]       parent;
    logic signed [Q_W-1:0]   qw;
    logic signed [Q_W-1:0]   qx;
    logic signed [Q_W-1:0]   qy;
    logic signed [Q_W-1:0]   qz;
  } cmd_t;

  // one skinning matrix element
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [BONE_W-1:0]       bone;
    logic [ELEM_W-1:0]       elem;
    logic                    last;
  } res_t;

endpackage

[rtl/ssme_front.sv]
// ----------------------------------------------------------------------------
// ssme_front: input classification and command queue
// Holds bone_count, drops items that touch no state, and queues the rest
// for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module ssme_front #(
  parameter int MAX_BONES = 128
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ssme_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_opcode,
  input  logic [ssme_pkg::BONE_W-1:0]          in_bone_index,
  input  logic [ssme_pkg::ELEM_W-1:0]          in_element_index,
  input  logic signed [ssme_pkg::VAL_W-1:0]    in_element_value,
  input  logic signed [7:0]                    in_parent_index,
  input  logic signed [ssme_pkg::Q_W-1:0]      in_quat_w,
  input  logic signed [ssme_pkg::Q_W-1:0]      in_quat_x,
  input  logic signed [ssme_pkg::Q_W-1:0]      in_quat_y,
  input  logic signed [ssme_pkg::Q_W-1:0]      in_quat_z,
  output logic                                 cmd_valid,
  output ssme_pkg::cmd_t                       cmd,
  input  logic                                 cmd_pop
);

  localparam int CW = 11;

  logic [ssme_pkg::CFG_W-1:0] bone_count_r;
  logic [CW-1:0]              active;
  logic                       pose_ok;
  logic                       load_ok;
  logic                       parent_ok;
  logic                       keep;
  logic                       accept;
  logic                       push_q;
  logic                       pop_q;
  ssme_pkg::cmd_t             new_cmd;
  ssme_pkg::cmd_t             q_r [2];
  logic                       wr_ptr_r;
  logic                       rd_ptr_r;
  logic [1:0]                 cnt_r;

  // bone count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bone_count_r <= '0;
    end else if (cfg_we) begin
      bone_count_r <= cfg_data;
    end
  end

  // effective bone count and classification
  assign active = (CW'(bone_count_r) < CW'(MAX_BONES)) ? CW'(bone_count_r) : CW'(MAX_BONES);
  assign pose_ok   = CW'(in_bone_index) < active;
  assign load_ok   = CW'(in_bone_index) < CW'(MAX_BONES);
  assign parent_ok = !in_parent_index[7] && (CW'(in_parent_index[6:0]) < active);
  assign keep      = (in_opcode == ssme_pkg::OP_POSE) ? pose_ok : load_ok;

  always_comb begin
    new_cmd.is_pose     = (in_opcode == ssme_pkg::OP_POSE);
    new_cmd.frame_start = (in_bone_index == '0);
    new_cmd.parent_ok   = parent_ok;
    new_cmd.bone        = in_bone_index;
    new_cmd.elem        = in_element_index;
    new_cmd.value       = in_element_value;
    new_cmd.parent      = in_parent_index[6:0];
    new_cmd.qw          = in_quat_w;
    new_cmd.qx          = in_quat_x;
    new_cmd.qy          = in_quat_y;
    new_cmd.qz          = in_quat_z;
  end

  // queue handshake
  assign in_full   = (cnt_r == 2'd2);
  assign accept    = in_push && !in_full;
  assign push_q    = accept && keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_q     = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_q) wr_ptr_r <= !wr_ptr_r;
      if (pop_q)  rd_ptr_r <= !rd_ptr_r;
      case ({push_q, pop_q})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_q) q_r[wr_ptr_r] <= new_cmd;
  end

endmodule

[rtl/ssme_back.sv]
// ----------------------------------------------------------------------------
// ssme_back: matrix sequencer
// Quaternion to rotation, parent world times rotation, world times inverse
// bind, all on one shared 32x32 multiplier; stores and result queue.
// ----------------------------------------------------------------------------
module ssme_back #(
  parameter int MAX_BONES = 128
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  ssme_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output ssme_pkg::res_t out_res
);

  localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int AW    = BW + 4;
  localparam int DEPTH = 2 ** AW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RPROD = 3'd1;
  localparam logic [2:0] S_ROT   = 3'd2;
  localparam logic [2:0] S_LDP   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  logic                 phase2_r, phase2_nxt;
  logic [ssme_pkg::VALID_DEPTH-1:0] valid_r;
  ssme_pkg::cmd_t       cur_r;
  logic                 root_r;
  logic                 root;
  logic signed [31:0]   qp_r    [9];
  logic signed [31:0]   left_r  [16];
  logic signed [31:0]   right_r [16];
  logic signed [31:0]   res_r   [16];
  logic signed [31:0]   rot     [16];
  logic signed [31:0]   mul_a, mul_b;
  logic signed [63:0]   prod_r;
  logic                 iss_v_r;
  logic [1:0]           iss_k_r;
  logic [3:0]           iss_e_r;
  logic signed [65:0]   acc_r;
  logic                 fin_v_r;
  logic [3:0]           fin_e_r;
  logic signed [65:0]   rnd;
  logic signed [31:0]   sat_val;
  logic signed [31:0]   ib_mem [DEPTH];
  logic signed [31:0]   w_mem  [DEPTH];
  logic signed [31:0]   ib_rd_r, w_rd_r;
  logic [AW-1:0]        cur_addr, par_addr, load_addr;
  logic [3:0]           c4;
  logic                 take;
  ssme_pkg::res_t       of_r [2];
  logic                 of_wp_r, of_rp_r;
  logic [1:0]           of_cnt_r;
  logic                 of_push, of_pop;

  // Q2.28 pair to Q16.16, round half up
  function automatic logic signed [31:0] rq(input logic signed [31:0] a,
                                            input logic signed [31:0] b,
                                            input logic sub);
    logic signed [34:0] t;
    t = sub ? (35'(a) - 35'(b)) : (35'(a) + 35'(b));
    t = (t <<< 1) + 35'sd2048;
    return 32'(t >>> 12);
  endfunction

  assign c4        = cnt_r[3:0];
  assign cur_addr  = {BW'(cur_r.bone), c4};
  assign par_addr  = {BW'(cur_r.parent), c4};
  assign load_addr = {BW'(cmd.bone), cmd.elem};
  assign take      = (state_r == S_IDLE) && cmd_valid;
  assign cmd_pop   = take;
  assign root      = !cmd.parent_ok || cmd.frame_start || !valid_r[cmd.parent];

  // rotation matrix from the quaternion products
  always_comb begin
    for (int i = 0; i < 16; i++) rot[i] = '0;
    rot[0]  = ssme_pkg::Q16_ONE - rq(qp_r[0], qp_r[1], 1'b0);
    rot[1]  = rq(qp_r[3], qp_r[4], 1'b0);
    rot[2]  = rq(qp_r[5], qp_r[6], 1'b1);
    rot[4]  = rq(qp_r[3], qp_r[4], 1'b1);
    rot[5]  = ssme_pkg::Q16_ONE - rq(qp_r[2], qp_r[1], 1'b0);
    rot[6]  = rq(qp_r[7], qp_r[8], 1'b0);
    rot[8]  = rq(qp_r[5], qp_r[6], 1'b0);
    rot[9]  = rq(qp_r[7], qp_r[8], 1'b1);
    rot[10] = ssme_pkg::Q16_ONE - rq(qp_r[2], qp_r[0], 1'b0);
    rot[15] = ssme_pkg::Q16_ONE;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_RPROD: begin
        case (c4)
          4'd0:    begin mul_a = 32'(cur_r.qy); mul_b = 32'(cur_r.qy); end
          4'd1:    begin mul_a = 32'(cur_r.qz); mul_b = 32'(cur_r.qz); end
          4'd2:    begin mul_a = 32'(cur_r.qx); mul_b = 32'(cur_r.qx); end
          4'd3:    begin mul_a = 32'(cur_r.qx); mul_b = 32'(cur_r.qy); end
          4'd4:    begin mul_a = 32'(cur_r.qw); mul_b = 32'(cur_r.qz); end
          4'd5:    begin mul_a = 32'(cur_r.qx); mul_b = 32'(cur_r.qz); end
          4'd6:    begin mul_a = 32'(cur_r.qw); mul_b = 32'(cur_r.qy); end
          4'd7:    begin mul_a = 32'(cur_r.qy); mul_b = 32'(cur_r.qz); end
          4'd8:    begin mul_a = 32'(cur_r.qw); mul_b = 32'(cur_r.qx); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      S_MUL: begin
        mul_a = left_r[{cnt_r[1:0], cnt_r[3:2]}];
        mul_b = right_r[{cnt_r[5:4], cnt_r[1:0]}];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // element rounding and saturation
  always_comb begin
    rnd = (acc_r + 66'sd32768) >>> 16;
    if (rnd > 66'sd2147483647)       sat_val = 32'sh7fffffff;
    else if (rnd < -66'sd2147483648) sat_val = 32'sh80000000;
    else                             sat_val = 32'(rnd);
  end

  // result queue handshake
  assign out_empty = (of_cnt_r == 2'd0);
  assign of_pop    = out_pop && !out_empty;
  assign of_push   = (state_r == S_EMIT) && (of_cnt_r != 2'd2);
  assign out_res   = of_r[of_rp_r];

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    phase2_nxt = phase2_r;
    case (state_r)
      S_IDLE: begin
        if (take && cmd.is_pose) begin
          state_nxt = S_RPROD;
          cnt_nxt   = '0;
        end
      end
      S_RPROD: begin
        if (cnt_r == 7'd9) begin
          state_nxt = S_ROT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_ROT: begin
        state_nxt  = root_r ? S_WB : S_LDP;
        cnt_nxt    = '0;
        phase2_nxt = 1'b0;
      end
      S_LDP: begin
        if (cnt_r == 7'd16) begin
          state_nxt = S_MUL;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_MUL: begin
        if (cnt_r == 7'd66) begin
          state_nxt = phase2_r ? S_EMIT : S_WB;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_WB: begin
        if (cnt_r == 7'd16) begin
          state_nxt  = S_MUL;
          cnt_nxt    = '0;
          phase2_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 7'd1;
        end
      end
      S_EMIT: begin
        if (of_push) begin
          if (c4 == 4'd15) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 7'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      phase2_r <= 1'b0;
      valid_r  <= '0;
      iss_v_r  <= 1'b0;
      fin_v_r  <= 1'b0;
      of_wp_r  <= 1'b0;
      of_rp_r  <= 1'b0;
      of_cnt_r <= 2'd0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      phase2_r <= phase2_nxt;
      iss_v_r  <= (state_r == S_MUL) && (cnt_r < 7'd64);
      fin_v_r  <= iss_v_r && (iss_k_r == 2'd3);
      // frame start clears marks, world write-back sets this bone's mark
      if (take && cmd.is_pose && cmd.frame_start) valid_r <= '0;
      if ((state_r == S_WB) && (cnt_r == 7'd16)) valid_r[cur_r.bone] <= 1'b1;
      if (of_push) of_wp_r <= !of_wp_r;
      if (of_pop)  of_rp_r <= !of_rp_r;
      case ({of_push, of_pop})
        2'b10:   of_cnt_r <= of_cnt_r + 2'd1;
        2'b01:   of_cnt_r <= of_cnt_r - 2'd1;
        default: of_cnt_r <= of_cnt_r;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    iss_k_r <= cnt_r[1:0];
    iss_e_r <= cnt_r[5:2];
    if (take) begin
      cur_r  <= cmd;
      root_r <= root;
    end
    // quaternion products
    if ((state_r == S_RPROD) && (cnt_r != 7'd0)) qp_r[c4 - 4'd1] <= prod_r[31:0];
    // rotation into the right operand, or straight into the world result
    if (state_r == S_ROT) begin
      for (int i = 0; i < 16; i++) begin
        right_r[i] <= rot[i];
        if (root_r) res_r[i] <= rot[i];
      end
    end
    // parent world into the left operand
    if ((state_r == S_LDP) && (cnt_r != 7'd0)) left_r[c4 - 4'd1] <= w_rd_r;
    // world to left operand, inverse bind to right operand
    if (state_r == S_WB) begin
      if (cnt_r < 7'd16)  left_r[c4] <= res_r[c4];
      if (cnt_r != 7'd0)  right_r[c4 - 4'd1] <= ib_rd_r;
    end
    // multiply-accumulate
    if (iss_v_r) begin
      if (iss_k_r == 2'd0) acc_r <= 66'(prod_r);
      else                 acc_r <= acc_r + 66'(prod_r);
      fin_e_r <= iss_e_r;
    end
    if (fin_v_r) res_r[fin_e_r] <= sat_val;
    // result queue storage
    if (of_push) begin
      of_r[of_wp_r].value <= res_r[c4];
      of_r[of_wp_r].bone  <= cur_r.bone;
      of_r[of_wp_r].elem  <= c4;
      of_r[of_wp_r].last  <= (c4 == 4'd15);
    end
  end

  // inverse bind store
  always_ff @(posedge clk) begin
    if (take && !cmd.is_pose) ib_mem[load_addr] <= cmd.value;
    ib_rd_r <= ib_mem[cur_addr];
  end

  // world store
  always_ff @(posedge clk) begin
    if ((state_r == S_WB) && (cnt_r < 7'd16)) w_mem[cur_addr] <= res_r[c4];
    w_rd_r <= w_mem[par_addr];
  end

endmodule

[rtl/skeletal_skin_matrix_engine.sv]
// ----------------------------------------------------------------------------
// skeletal_skin_matrix_engine: per-bone skinning matrix engine
// Front end classifies items into a short queue, back end builds world and
// skinning matrices and streams them out.
// ----------------------------------------------------------------------------
// Load items are written straight into the inverse bind store. The work of a
// pose item is set by the single 32x32 multiplier, which runs the nine
// quaternion products and 64 multiply-accumulates per 4x4 product (one such
// product when the parent is a root, two otherwise), plus store transfers and
// the 16 result transfers. A two-entry command queue lets new items be taken
// while a bone is being worked on.
module skeletal_skin_matrix_engine #(
  parameter int MAX_BONES = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ssme_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_opcode,
  input  logic [ssme_pkg::BONE_W-1:0]       in_bone_index,
  input  logic [ssme_pkg::ELEM_W-1:0]       in_element_index,
  input  logic signed [ssme_pkg::VAL_W-1:0] in_element_value,
  input  logic signed [7:0]                 in_parent_index,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_w,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_x,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_y,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_z,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [ssme_pkg::VAL_W-1:0] out_skin_value,
  output logic [ssme_pkg::BONE_W-1:0]       out_skin_bone,
  output logic [ssme_pkg::ELEM_W-1:0]       out_skin_element,
  output logic                              out_last_element
);

  logic           cmd_valid;
  logic           cmd_pop;
  ssme_pkg::cmd_t cmd;
  ssme_pkg::res_t res;

  // classification and command queue
  ssme_front #(.MAX_BONES(MAX_BONES)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_opcode        (in_opcode),
    .in_bone_index    (in_bone_index),
    .in_element_index (in_element_index),
    .in_element_value (in_element_value),
    .in_parent_index  (in_parent_index),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  // matrix sequencer
  ssme_back #(.MAX_BONES(MAX_BONES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (res)
  );

  // result fields
  assign out_skin_value   = res.value;
  assign out_skin_bone    = res.bone;
  assign out_skin_element = res.elem;
  assign out_last_element = res.last;

endmodule

[rtl/ssme_checker.sv]
// ----------------------------------------------------------------------------
// ssme_checker: port-level checks of the skinning matrix engine
// Watches the result stream ordering and reset behaviour at the ports.
// ----------------------------------------------------------------------------
module ssme_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_we,
  input logic [ssme_pkg::CFG_W-1:0]        cfg_data,
  input logic                              in_push,
  input logic                              in_full,
  input logic                              in_opcode,
  input logic [ssme_pkg::BONE_W-1:0]       in_bone_index,
  input logic [ssme_pkg::ELEM_W-1:0]       in_element_index,
  input logic signed [ssme_pkg::VAL_W-1:0] in_element_value,
  input logic signed [7:0]                 in_parent_index,
  input logic signed [ssme_pkg::Q_W-1:0]   in_quat_w,
  input logic signed [ssme_pkg::Q_W-1:0]   in_quat_x,
  input logic signed [ssme_pkg::Q_W-1:0]   in_quat_y,
  input logic signed [ssme_pkg::Q_W-1:0]   in_quat_z,
  input logic                              out_empty,
  input logic                              out_pop,
  input logic signed [ssme_pkg::VAL_W-1:0] out_skin_value,
  input logic [ssme_pkg::BONE_W-1:0]       out_skin_bone,
  input logic [ssme_pkg::ELEM_W-1:0]       out_skin_element,
  input logic                              out_last_element
);

  // reset leaves nothing to deliver and room for input
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("result queue not empty or input full after reset");

  // last flag marks element fifteen only
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_last_element == (out_skin_element == 4'd15)))
    else $error("last flag does not match element index");

  // within a matrix, elements follow in order for the same bone
  a_elem_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_element) ##1 !out_empty |->
      (out_skin_element == 4'($past(out_skin_element, 1) + 4'd1)) &&
      (out_skin_bone == $past(out_skin_bone, 1)))
    else $error("matrix elements out of order");

  // a waiting result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_skin_value) &&
      $stable(out_skin_element)))
    else $error("waiting result changed");

endmodule

bind skeletal_skin_matrix_engine ssme_checker u_ssme_checker (.*);

[bench/skin_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_checker: prediction and checking for the skinning matrix engine
// Watches the configuration port and both channels, keeps its own copy of the
// inverse bind, world and valid stores, predicts the sixteen elements of each
// posed bone and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module skin_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ssme_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic                              in_opcode,
  input  logic [ssme_pkg::BONE_W-1:0]       in_bone_index,
  input  logic [ssme_pkg::ELEM_W-1:0]       in_element_index,
  input  logic signed [ssme_pkg::VAL_W-1:0] in_element_value,
  input  logic signed [7:0]                 in_parent_index,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_w,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_x,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_y,
  input  logic signed [ssme_pkg::Q_W-1:0]   in_quat_z,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic signed [ssme_pkg::VAL_W-1:0] out_skin_value,
  input  logic [ssme_pkg::BONE_W-1:0]       out_skin_bone,
  input  logic [ssme_pkg::ELEM_W-1:0]       out_skin_element,
  input  logic                              out_last_element,
  output int                                errors,
  output int                                pending,
  output int                                results_seen
);

  localparam int NBONES = 128;

  typedef logic signed [ssme_pkg::VAL_W-1:0] mat_t [16];

  logic signed [ssme_pkg::VAL_W-1:0] inv_bind [NBONES*16];
  logic signed [ssme_pkg::VAL_W-1:0] world [NBONES*16];
  logic                              world_ok [NBONES];
  logic [ssme_pkg::CFG_W-1:0]        bone_count;
  ssme_pkg::res_t                    skin_q [$];

  // clamp to the signed 32-bit range
  function automatic logic signed [ssme_pkg::VAL_W-1:0] clamp32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Q2.28 down to Q16.16, round half up
  function automatic logic signed [63:0] q28_round(logic signed [63:0] v);
    return (v + 64'sd2048) >>> 12;
  endfunction

  // rotation matrix from a quaternion, column major
  function automatic mat_t quat_to_rot(logic signed [63:0] w, logic signed [63:0] x,
                                       logic signed [63:0] y, logic signed [63:0] z);
    mat_t m;
    for (int i = 0; i < 16; i++) m[i] = '0;
    m[0]  = clamp32(128'(64'sd65536 - q28_round(2 * (y * y + z * z))));
    m[1]  = clamp32(128'(q28_round(2 * (x * y + w * z))));
    m[2]  = clamp32(128'(q28_round(2 * (x * z - w * y))));
    m[4]  = clamp32(128'(q28_round(2 * (x * y - w * z))));
    m[5]  = clamp32(128'(64'sd65536 - q28_round(2 * (x * x + z * z))));
    m[6]  = clamp32(128'(q28_round(2 * (y * z + w * x))));
    m[8]  = clamp32(128'(q28_round(2 * (x * z + w * y))));
    m[9]  = clamp32(128'(q28_round(2 * (y * z - w * x))));
    m[10] = clamp32(128'(64'sd65536 - q28_round(2 * (x * x + y * y))));
    m[15] = ssme_pkg::Q16_ONE;
    return m;
  endfunction

  // 4x4 product, exact sum then round half up and saturate
  function automatic mat_t mat_product(mat_t a, mat_t b);
    mat_t r;
    logic signed [127:0] acc;
    for (int c = 0; c < 4; c++)
      for (int rw = 0; rw < 4; rw++) begin
        acc = '0;
        for (int k = 0; k < 4; k++)
          acc += 128'(a[k*4+rw]) * 128'(b[c*4+k]);
        r[c*4+rw] = clamp32((acc + 128'sd32768) >>> 16);
      end
    return r;
  endfunction

  // world update and skinning prediction for one pose transfer
  task automatic predict_pose();
    int unsigned    active;
    int             par;
    mat_t           rot, pw, wm, ib, sk;
    ssme_pkg::res_t r;
    active = (bone_count < NBONES) ? bone_count : NBONES;
    if (in_bone_index >= active) return;
    if (in_bone_index == 0)
      for (int i = 0; i < NBONES; i++) world_ok[i] = 1'b0;
    rot = quat_to_rot(in_quat_w, in_quat_x, in_quat_y, in_quat_z);
    par = in_parent_index;
    if (par >= 0 && par < active && world_ok[par]) begin
      for (int i = 0; i < 16; i++) pw[i] = world[par*16+i];
      wm = mat_product(pw, rot);
    end else begin
      wm = rot;
    end
    for (int i = 0; i < 16; i++) begin
      world[in_bone_index*16+i] = wm[i];
      ib[i] = inv_bind[in_bone_index*16+i];
    end
    world_ok[in_bone_index] = 1'b1;
    sk = mat_product(wm, ib);
    for (int e = 0; e < 16; e++) begin
      r.value = sk[e];
      r.bone  = in_bone_index;
      r.elem  = e[ssme_pkg::ELEM_W-1:0];
      r.last  = (e == 15);
      skin_q.push_back(r);
    end
  endtask

  // watch every transfer on the rising edge
  always @(posedge clk) begin
    ssme_pkg::res_t want;
    if (!rst_n) begin
      bone_count = '0;
      for (int i = 0; i < NBONES; i++) world_ok[i] = 1'b0;
      skin_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) bone_count = cfg_data;
      if (in_push && !in_full) begin
        if (in_opcode == ssme_pkg::OP_LOAD)
          inv_bind[in_bone_index*16+in_element_index] = in_element_value;
        else
          predict_pose();
      end
      if (out_pop && !out_empty) begin
        results_seen++;
        if (skin_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected result transfer: bone %0d element %0d value %0d",
                     $time, out_skin_bone, out_skin_element, out_skin_value);
        end else begin
          want = skin_q.pop_front();
          if (out_skin_value !== want.value || out_skin_bone !== want.bone ||
              out_skin_element !== want.elem || out_last_element !== want.last) begin
            errors++;
            if (errors <= 10)
              $display({"[%0t] mismatch: expected value %0d bone %0d element %0d last %0b,",
                        " got value %0d bone %0d element %0d last %0b"}, $time,
                       want.value, want.bone, want.elem, want.last, out_skin_value,
                       out_skin_bone, out_skin_element, out_last_element);
          end
        end
      end
    end
    pending = skin_q.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the skinning matrix engine
// Loads inverse bind matrices, poses bone hierarchies under several bone
// counts with random quaternions and random idling on both channels; the
// checker predicts and compares every skinning element.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 300;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic [ssme_pkg::CFG_W-1:0]        cfg_data;
  logic                              in_push;
  logic                              in_full;
  logic                              in_opcode;
  logic [ssme_pkg::BONE_W-1:0]       in_bone_index;
  logic [ssme_pkg::ELEM_W-1:0]       in_element_index;
  logic signed [ssme_pkg::VAL_W-1:0] in_element_value;
  logic signed [7:0]                 in_parent_index;
  logic signed [ssme_pkg::Q_W-1:0]   in_quat_w, in_quat_x, in_quat_y, in_quat_z;
  logic                              out_empty;
  logic                              out_pop;
  logic signed [ssme_pkg::VAL_W-1:0] out_skin_value;
  logic [ssme_pkg::BONE_W-1:0]       out_skin_bone;
  logic [ssme_pkg::ELEM_W-1:0]       out_skin_element;
  logic                              out_last_element;
  int                                errors, pending, results_seen;

  int          cycles;
  bit          quiet;
  int          items_sent, poses_sent, settings_used;
  logic [15:0] loaded [128];
  logic [ssme_pkg::CFG_W-1:0] cur_count;

  skeletal_skin_matrix_engine #(.MAX_BONES(128)) u_top (.*);

  skin_checker u_check (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: pop with random stall bursts
  always @(negedge clk) begin
    int stall;
    if (stall > 0) begin
      stall--;
      out_pop = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall = $urandom_range(1, 13) - 1;
      out_pop = 1'b0;
    end else begin
      out_pop = 1'b1;
    end
  end

  // one input transfer, with an optional idle burst ahead of it
  task automatic send(logic op, logic [ssme_pkg::BONE_W-1:0] bone,
                      logic [ssme_pkg::ELEM_W-1:0] elem,
                      logic signed [ssme_pkg::VAL_W-1:0] val, logic signed [7:0] par,
                      logic signed [ssme_pkg::Q_W-1:0] w, logic signed [ssme_pkg::Q_W-1:0] x,
                      logic signed [ssme_pkg::Q_W-1:0] y, logic signed [ssme_pkg::Q_W-1:0] z);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    in_push = 1'b0;
    repeat (gap) @(negedge clk);
    in_opcode = op; in_bone_index = bone; in_element_index = elem;
    in_element_value = val; in_parent_index = par;
    in_quat_w = w; in_quat_x = x; in_quat_y = y; in_quat_z = z;
    in_push = 1'b1;
    do @(posedge clk); while (in_full);
    @(negedge clk);
    in_push = 1'b0;
    items_sent++;
    if (op == ssme_pkg::OP_POSE) poses_sent++;
    if (op == ssme_pkg::OP_LOAD) loaded[bone][elem] = 1'b1;
  endtask

  task automatic load(logic [ssme_pkg::BONE_W-1:0] bone, logic [ssme_pkg::ELEM_W-1:0] elem,
                      logic signed [ssme_pkg::VAL_W-1:0] val);
    send(ssme_pkg::OP_LOAD, bone, elem, val, 8'($urandom), 16'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom));
  endtask

  task automatic pose(logic [ssme_pkg::BONE_W-1:0] bone, logic signed [7:0] par,
                      logic signed [ssme_pkg::Q_W-1:0] w, logic signed [ssme_pkg::Q_W-1:0] x,
                      logic signed [ssme_pkg::Q_W-1:0] y, logic signed [ssme_pkg::Q_W-1:0] z);
    send(ssme_pkg::OP_POSE, bone, 4'($urandom), $urandom, par, w, x, y, z);
  endtask

  function automatic logic signed [ssme_pkg::Q_W-1:0] rand_q();
    return ssme_pkg::Q_W'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  // a pose is allowed only if it cannot read an unloaded inverse bind element
  function automatic bit pose_ok(int bone);
    int active;
    active = (cur_count < 128) ? cur_count : 128;
    return bone >= active || loaded[bone] == 16'hffff;
  endfunction

  // reconfigure once the engine has drained
  task automatic set_bone_count(logic [ssme_pkg::CFG_W-1:0] v);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1; cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_count = v;
    settings_used++;
  endtask

  // one frame of random poses over bones that are ready
  task automatic random_frame();
    int n, b, p;
    n = $urandom_range(2, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: b = 127;
        1: b = $urandom_range(0, 127);
        default: b = (i == 0) ? 0 : $urandom_range(0, 4);
      endcase
      if (!pose_ok(b)) b = 0;
      p = ($urandom_range(0, 4) == 0) ? $signed($urandom_range(0, 255)) - 128
                                       : $urandom_range(0, 4);
      pose(7'(b), 8'(p), rand_q(), rand_q(), rand_q(), rand_q());
      if ($urandom_range(0, 3) == 0)
        load(7'($urandom_range(0, 127)), 4'($urandom), $urandom);
    end
  endtask

  initial begin
    quiet = 0; items_sent = 0; poses_sent = 0; settings_used = 0;
    for (int i = 0; i < 128; i++) loaded[i] = '0;
    rst_n = 1'b0; cfg_we = 1'b0; cfg_data = '0; in_push = 1'b0;
    in_opcode = ssme_pkg::OP_LOAD; in_bone_index = '0; in_element_index = '0;
    in_element_value = '0; in_parent_index = '0;
    in_quat_w = '0; in_quat_x = '0; in_quat_y = '0; in_quat_z = '0;
    cur_count = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // bone count zero after reset: poses are ignored
    pose(0, -1, 16384, 0, 0, 0);

    // inverse bind matrices for bones 0..4 and 127, identity-like with noise
    for (int b = 0; b <= 5; b++)
      for (int e = 0; e < 16; e++)
        load(7'((b == 5) ? 127 : b), 4'(e),
             (e % 5 == 0) ? 32'sd65536 + $signed($urandom_range(0, 8191)) - 4096
                          : $signed($urandom_range(0, 32767)) - 16384);
    load(1, 3, 32'sh7fffffff);
    load(2, 6, 32'sh80000000);

    set_bone_count(4);
    // directed poses: root, chains, extremes of the quaternion, odd parents
    pose(0, -1, 16384, 0, 0, 0);
    pose(1, 0, -16384, 0, 0, 0);
    pose(2, 1, 16384, 16384, 16384, 16384);
    pose(3, 2, -16384, -16384, -16384, -16384);
    pose(1, 3, 0, 0, 0, 0);
    pose(2, -128, 0, 16384, 0, 0);
    pose(3, 127, 0, 0, 16384, 0);
    pose(1, 100, 0, 0, 0, -16384);
    pose(2, 3, 11585, 11585, 0, 0);
    pose(4, 0, 16384, 0, 0, 0);
    pose(127, 0, 16384, 0, 0, 0);
    pose(0, 0, 16384, 0, 0, 0);
    pose(3, 0, -1, 1, -1, 1);
    load(1, 3, 32'sh0000ffff);
    load(2, 6, 32'sh00010000);

    // several bone counts, the extremes among them
    set_bone_count(128);
    pose(127, 3, 16384, 16384, -16384, 16384);
    pose(0, -1, rand_q(), rand_q(), rand_q(), rand_q());
    pose(127, 0, rand_q(), rand_q(), rand_q(), rand_q());
    while (items_sent < 160) random_frame();
    set_bone_count(255);
    while (items_sent < 200) random_frame();
    set_bone_count(1);
    while (items_sent < 225) random_frame();
    set_bone_count(4);
    while (items_sent < 240) random_frame();
    quiet = 1;
    while (items_sent < 250) random_frame();

    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d items (%0d poses) over %0d bone counts; %0d skin elements checked",
             items_sent, poses_sent, settings_used, results_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
